/* src/mart_pkg.sv */
// Shared types and constants for the moving average reversion trigger.
`default_nettype none
package mart_pkg;

    localparam int WINLEN_W = 7;
    localparam int QTY_W = 16;
    localparam int ORDER_ID_W = 32;
    localparam int TIME_W = 64;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER_QUANTITY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ORDER_ID = 2'd2;

    localparam logic [WINLEN_W-1:0] WINLEN_RESET = 7'd20;
    localparam logic [QTY_W-1:0] QTY_RESET = 16'd1;
    localparam logic [ORDER_ID_W-1:0] ORDER_ID_RESET = 32'd0;

    localparam int DEFAULT_PRICE = 10000;
    localparam int BAND_SHIFT = 2;

    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/mart_cell.sv */
// One stage of the price delay line that holds the window.
`default_nettype none
module mart_cell #(
    parameter int PRICE_BITS = 24
) (
    input  wire                         aclk,
    input  wire mart_pkg::cell_ctrl_t   ctrl,
    input  wire [PRICE_BITS-1:0]        new_price,
    input  wire [PRICE_BITS-1:0]        prev_price,
    output logic [PRICE_BITS-1:0]       price_q
);
    import mart_pkg::*;

    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] price_next;

    always_comb begin
        price_next = price_reg;
        if (ctrl.shift) begin
            price_next = ctrl.load ? new_price : prev_price;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg <= price_next;
    end

    assign price_q = price_reg;

endmodule
`default_nettype wire

/* src/moving_average_reversion_trigger.sv */
// Top level of the moving average reversion trigger.
`default_nettype none
// Takes one market data word per clock and, once the window holds
// window_length prices, emits a buy one tick above the price when it sits more
// than 0.05 below the mean, or a sell one tick below when it sits more than
// 0.05 above it. Prices pass through a delay line of WINDOW_MAX cells; a new
// price enters the cell WINDOW_MAX - window_length, so the last cell always
// yields the price that leaves the running sum. A word's order passes the p1
// stage, which updates the sum and forms price times window, then the output
// register, which holds the band compare result. While an order waits for
// m_ready, one more word is taken and the input then stalls until the order
// is accepted. Writing window_length empties the window; the first
// window_length - 1 words after it emit nothing.
module moving_average_reversion_trigger #(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 24
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire [mart_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [mart_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_sell_present,
    input  wire [PRICE_BITS-1:0]                  s_sell_price,
    input  wire                                   s_buy_present,
    input  wire [PRICE_BITS-1:0]                  s_buy_price,
    input  wire [mart_pkg::TIME_W-1:0]            s_tick_time,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [mart_pkg::ORDER_ID_W-1:0]       m_order_number,
    output logic                                  m_side,
    output logic [PRICE_BITS-1:0]                 m_limit_price,
    output logic [mart_pkg::QTY_W-1:0]            m_quantity,
    output logic [mart_pkg::TIME_W-1:0]           m_order_time
);
    import mart_pkg::*;

    localparam int WB = $clog2(WINDOW_MAX + 1);
    localparam int CB = (WB > WINLEN_W) ? WB : WINLEN_W;
    localparam int SUM_BITS = PRICE_BITS + WB;
    localparam int CMP_BITS = SUM_BITS + 1;

    logic [WINLEN_W-1:0]   winlen_reg;
    logic [QTY_W-1:0]      qty_reg;
    logic [ORDER_ID_W-1:0] cnt_reg;
    logic [ORDER_ID_W-1:0] cnt_next;

    logic [WB-1:0]         filled_reg;
    logic [WB-1:0]         filled_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;

    logic                  p1_valid_reg;
    logic                  p1_valid_next;
    logic                  p1_eval_reg;
    logic [PRICE_BITS-1:0] p1_price_reg;
    logic [SUM_BITS-1:0]   p1_sum_reg;
    logic [SUM_BITS-1:0]   p1_scaled_reg;
    logic [WB-1:0]         p1_w_reg;
    logic [TIME_W-1:0]     p1_time_reg;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [ORDER_ID_W-1:0] m_order_reg;
    logic                  m_side_reg;
    logic [PRICE_BITS-1:0] m_limit_reg;
    logic [QTY_W-1:0]      m_qty_reg;
    logic [TIME_W-1:0]     m_time_reg;

    logic [CB-1:0]         wl_ext;
    logic [CB-1:0]         w_clamp;
    logic [WB-1:0]         w_eff;
    logic [PRICE_BITS-1:0] price;
    logic                  accept;
    logic                  adv;
    logic                  full;
    logic [PRICE_BITS-1:0] old_price;
    logic [CMP_BITS-1:0]   band;
    logic [CMP_BITS-1:0]   scaled_ext;
    logic [CMP_BITS-1:0]   sum_ext;
    logic                  buy_hit;
    logic                  sell_hit;
    logic                  emit;
    logic [PRICE_BITS-1:0] buy_limit;
    logic [PRICE_BITS-1:0] sell_limit;
    logic                  cfg_win_wr;
    logic                  cfg_id_wr;

    logic [PRICE_BITS-1:0] cell_q [WINDOW_MAX];
    cell_ctrl_t            cell_ctrl [WINDOW_MAX];

    assign cfg_win_wr = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
    assign cfg_id_wr = cfg_we && (cfg_index == REG_FIRST_ORDER_ID);

    always_comb begin
        wl_ext = CB'(winlen_reg);
        if (wl_ext == '0) begin
            w_clamp = CB'(1);
        end else if (wl_ext > CB'(WINDOW_MAX)) begin
            w_clamp = CB'(WINDOW_MAX);
        end else begin
            w_clamp = wl_ext;
        end
        w_eff = WB'(w_clamp);
    end

    always_comb begin
        if (s_sell_present) begin
            price = s_sell_price;
        end else if (s_buy_present) begin
            price = s_buy_price;
        end else begin
            price = PRICE_BITS'(DEFAULT_PRICE);
        end
    end

    assign adv = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || adv;
    assign accept = s_valid && s_ready;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            assign cell_ctrl[gi].shift = accept;
            assign cell_ctrl[gi].load = (w_eff == WB'(WINDOW_MAX - gi));
            if (gi == 0) begin : g_head
                mart_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl[gi]),
                    .new_price (price),
                    .prev_price(price),
                    .price_q   (cell_q[gi])
                );
            end else begin : g_body
                mart_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl[gi]),
                    .new_price (price),
                    .prev_price(cell_q[gi-1]),
                    .price_q   (cell_q[gi])
                );
            end
        end
    endgenerate

    assign full = (filled_reg >= w_eff);
    assign old_price = full ? cell_q[WINDOW_MAX-1] : '0;

    always_comb begin
        filled_next = filled_reg;
        sum_next = sum_reg;
        if (cfg_win_wr) begin
            filled_next = '0;
            sum_next = '0;
        end else if (accept) begin
            sum_next = sum_reg + SUM_BITS'(price) - SUM_BITS'(old_price);
            if (!full) begin
                filled_next = filled_reg + WB'(1);
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (adv) begin
            p1_valid_next = 1'b0;
        end
    end

    assign band = (CMP_BITS'(p1_w_reg) << BAND_SHIFT) + CMP_BITS'(p1_w_reg);
    assign scaled_ext = CMP_BITS'(p1_scaled_reg);
    assign sum_ext = CMP_BITS'(p1_sum_reg);
    assign buy_hit = (scaled_ext + band) < sum_ext;
    assign sell_hit = scaled_ext > (sum_ext + band);
    assign emit = p1_valid_reg && p1_eval_reg && (buy_hit || sell_hit);
    assign buy_limit = (p1_price_reg == '1) ? p1_price_reg : p1_price_reg + PRICE_BITS'(1);
    assign sell_limit = (p1_price_reg == '0) ? p1_price_reg : p1_price_reg - PRICE_BITS'(1);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = emit;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_id_wr) begin
            cnt_next = cfg_data[ORDER_ID_W-1:0];
        end else if (adv && emit) begin
            cnt_next = cnt_reg + ORDER_ID_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            winlen_reg <= WINLEN_RESET;
            qty_reg <= QTY_RESET;
            cnt_reg <= ORDER_ID_RESET;
            filled_reg <= '0;
            sum_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_win_wr) begin
                winlen_reg <= cfg_data[WINLEN_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_ORDER_QUANTITY)) begin
                qty_reg <= cfg_data[QTY_W-1:0];
            end
            cnt_reg <= cnt_next;
            filled_reg <= filled_next;
            sum_reg <= sum_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_eval_reg <= (filled_next >= w_eff);
            p1_price_reg <= price;
            p1_sum_reg <= sum_next;
            p1_scaled_reg <= SUM_BITS'(price) * SUM_BITS'(w_eff);
            p1_w_reg <= w_eff;
            p1_time_reg <= s_tick_time;
        end
        if (adv && emit) begin
            m_order_reg <= cnt_reg;
            m_side_reg <= buy_hit ? SIDE_BUY : SIDE_SELL;
            m_limit_reg <= buy_hit ? buy_limit : sell_limit;
            m_qty_reg <= qty_reg;
            m_time_reg <= p1_time_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_order_number = m_order_reg;
    assign m_side = m_side_reg;
    assign m_limit_price = m_limit_reg;
    assign m_quantity = m_qty_reg;
    assign m_order_time = m_time_reg;

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (filled_reg <= w_eff) || (winlen_reg != $past(winlen_reg)))
        else $error("Window fill count exceeds the window length.");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && emit && !cfg_we) |=> (cnt_reg == $past(cnt_reg) + ORDER_ID_W'(1)))
        else $error("Order number did not advance on an emitted order.");

    a_emit_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_we && (filled_next < w_eff)) |=> !p1_eval_reg)
        else $error("Word evaluated before the window was full.");

endmodule
`default_nettype wire
